// ===== sv/itbl_pkg.sv =====
// Shared constants, codes and types of the indexed insert/delete table.
`default_nettype none

package itbl_pkg;

	// Default sizes.
	localparam int TABLE_DEPTH_DEF = 64;
	localparam int KEY_BITS_DEF    = 64;
	localparam int DATA_BITS_DEF   = 64;

	// Fixed field widths of the stream payloads.
	localparam int CMD_BITS    = 2;
	localparam int POS_BITS    = 6;
	localparam int NR_BITS     = 7;
	localparam int WORD_BITS   = 64;
	localparam int STATUS_BITS = 2;
	localparam int COUNT_BITS  = 7;
	localparam int CAP_BITS    = 7;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

	// Commands.
	localparam logic [CMD_BITS-1:0] CMD_READ   = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_DELETE = 2'd2;
	localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd3;

	// Result status codes.
	localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd2;

	// Operations broadcast along the row of cells.
	localparam logic [1:0] OP_HOLD       = 2'd0;
	localparam logic [1:0] OP_INSERT     = 2'd1;
	localparam logic [1:0] OP_SHIFT_DOWN = 2'd2;
	localparam logic [1:0] OP_CLEAR      = 2'd3;

	typedef struct packed {
		logic [1:0]          op;
		logic [POS_BITS-1:0] pos;
	} itbl_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/indexed_insert_delete_table.sv =====
// Top level of the indexed insert/delete table built as a row of slot cells.
// Usage:
//   Commands arrive on the s_ stream; each transfer carries one command in
//   s_tuser and its operands in s_tdata. Every command produces exactly one
//   result transfer on the m_ stream, holding a status, the pair read (zero
//   unless a read succeeds) and the entry count after the command.
//   Read, insert, clear and a delete that removes nothing load the result
//   register at the edge that accepts the command.
//   A delete that removes n entries walks the row down by one slot per cycle
//   and marks its result valid at the edge of its last shift.
//   Only one command is in the block at a time. A new command is accepted in
//   the same cycle the previous result is taken, so back-to-back commands that
//   need no shifts sustain one per cycle when the receiver keeps m_tready high.
//   If the receiver stalls, the result waits in the output register and
//   s_tready stays low until it is taken.
//   The capacity limit is written through cfg_we/cfg_wdata while idle.
//   Reset zeroes every slot and the entry count and sets the limit to 64;
//   there is no clearing pass, the block is ready right after reset.
`default_nettype none

module indexed_insert_delete_table import itbl_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF,
	parameter int DATA_BITS   = DATA_BITS_DEF
) (
	input  wire  logic                clk,
	input  wire  logic                arst_n,
	input  wire  logic                cfg_we,
	input  wire  logic [CAP_BITS-1:0] cfg_wdata,   // capacity_limit
	input  wire  logic                s_tvalid,
	output logic                      s_tready,
	// entry_index [5:0], remove_count [12:6], key_in [76:13], data_in [140:77]
	input  wire  logic [143:0]        s_tdata,
	input  wire  logic [CMD_BITS-1:0] s_tuser,     // command [1:0]
	output logic                      m_tvalid,
	input  wire  logic                m_tready,
	// status [1:0], key_out [65:2], data_out [129:66], entry_count_now [136:130]
	output logic [143:0]              m_tdata
);

	// Count register must hold TABLE_DEPTH itself; compares run at the wider of
	// that and the 7-bit fields.
	localparam int CW       = $clog2(TABLE_DEPTH + 1);
	localparam int CMPW     = (CW > NR_BITS) ? CW : NR_BITS;
	localparam int IDX_BITS = $clog2(TABLE_DEPTH);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DEL  = 1'b1;

	// Unpacked input fields.
	logic [CMD_BITS-1:0]  in_cmd;
	logic [POS_BITS-1:0]  in_pos;
	logic [NR_BITS-1:0]   in_nr;
	logic [KEY_BITS-1:0]  in_key;
	logic [DATA_BITS-1:0] in_data;

	assign in_cmd  = s_tuser;
	assign in_pos  = s_tdata[5:0];
	assign in_nr   = s_tdata[12:6];
	assign in_key  = s_tdata[13 +: KEY_BITS];
	assign in_data = s_tdata[77 +: DATA_BITS];

	// Control and bookkeeping registers.
	logic                 state_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        rem_q;
	logic [POS_BITS-1:0]  pos_q;
	logic [CAP_BITS-1:0]  cap_q;

	// Output register.
	logic                   out_valid_q;
	logic [STATUS_BITS-1:0] out_status_q;
	logic [KEY_BITS-1:0]    out_key_q;
	logic [DATA_BITS-1:0]   out_data_q;
	logic [CW-1:0]          out_cnt_q;

	logic accept;
	logic out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	// Command decode at the accepting edge.
	logic [CMPW-1:0] pos_c, cnt_c, nr_c, lim_c, avail_c, n_c;
	logic            rd_ok, ins_range, ins_full, del_range;

	assign pos_c     = CMPW'(in_pos);
	assign cnt_c     = CMPW'(cnt_q);
	assign nr_c      = CMPW'(in_nr);
	assign lim_c     = (CMPW'(cap_q) < CMPW'(TABLE_DEPTH)) ? CMPW'(cap_q) : CMPW'(TABLE_DEPTH);
	assign avail_c   = cnt_c - pos_c;
	assign n_c       = (nr_c < avail_c) ? nr_c : avail_c;
	assign rd_ok     = pos_c < cnt_c;
	assign ins_range = pos_c > cnt_c;
	assign ins_full  = cnt_c >= lim_c;
	assign del_range = pos_c >= cnt_c;

	// Broadcast to the cells: an accepted good insert or a clear acts at once,
	// a delete shifts the row down one slot per cycle while in ST_DEL.
	itbl_ctrl_t ctrl;

	always_comb begin
		ctrl.op  = OP_HOLD;
		ctrl.pos = in_pos;
		if (state_q == ST_DEL) begin
			ctrl.op  = OP_SHIFT_DOWN;
			ctrl.pos = pos_q;
		end else if (accept) begin
			case (in_cmd)
				CMD_INSERT: if (!ins_range && !ins_full) ctrl.op = OP_INSERT;
				CMD_CLEAR:  ctrl.op = OP_CLEAR;
				default:    ctrl.op = OP_HOLD;
			endcase
		end
	end

	// Row of cells.
	logic [KEY_BITS-1:0]  key_row  [TABLE_DEPTH];
	logic [DATA_BITS-1:0] data_row [TABLE_DEPTH];
	logic [KEY_BITS-1:0]  key_bus  [TABLE_DEPTH];
	logic [DATA_BITS-1:0] data_bus [TABLE_DEPTH];

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		logic [KEY_BITS-1:0]  key_l, key_r;
		logic [DATA_BITS-1:0] data_l, data_r;

		if (g == 0) begin : g_first
			assign key_l  = '0;
			assign data_l = '0;
		end else begin : g_mid_l
			assign key_l  = key_row[g-1];
			assign data_l = data_row[g-1];
		end
		if (g == TABLE_DEPTH - 1) begin : g_last
			assign key_r  = '0;
			assign data_r = '0;
		end else begin : g_mid_r
			assign key_r  = key_row[g+1];
			assign data_r = data_row[g+1];
		end

		itbl_cell #(
			.KEY_BITS  (KEY_BITS),
			.DATA_BITS (DATA_BITS),
			.IDX_BITS  (IDX_BITS),
			.CELL_IDX  (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.key_new    (in_key),
			.data_new   (in_data),
			.key_left   (key_l),
			.data_left  (data_l),
			.key_right  (key_r),
			.data_right (data_r),
			.key_q      (key_row[g]),
			.data_q     (data_row[g]),
			.key_sel    (key_bus[g]),
			.data_sel   (data_bus[g])
		);
	end

	// Read: OR together the one-hot selected cell outputs.
	logic [KEY_BITS-1:0]  rd_key;
	logic [DATA_BITS-1:0] rd_data;

	always_comb begin
		rd_key  = '0;
		rd_data = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			rd_key  = rd_key | key_bus[i];
			rd_data = rd_data | data_bus[i];
		end
	end

	// Sequencer, count and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rem_q       <= '0;
			pos_q       <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end

			if (state_q == ST_DEL) begin
				rem_q <= rem_q - CW'(1);
				if (rem_q == CW'(1)) begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
				end
			end else if (accept) begin
				case (in_cmd)
					CMD_READ: begin
						out_valid_q <= 1'b1;
					end
					CMD_INSERT: begin
						out_valid_q <= 1'b1;
						if (!ins_range && !ins_full) begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
					CMD_DELETE: begin
						pos_q <= in_pos;
						if (del_range || n_c == '0) begin
							out_valid_q <= 1'b1;
						end else begin
							// The count drops now; the result goes out after the shifts.
							state_q <= ST_DEL;
							rem_q   <= CW'(n_c);
							cnt_q   <= CW'(cnt_c - n_c);
						end
					end
					default: begin
						cnt_q       <= '0;
						out_valid_q <= 1'b1;
					end
				endcase
			end
		end
	end

	// Result payload; loaded at the accepting edge, also for a delete whose valid flag is set only after its shifts.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_key_q    <= '0;
			out_data_q   <= '0;
			out_status_q <= ST_OK;
			out_cnt_q    <= cnt_q;
			case (in_cmd)
				CMD_READ: begin
					if (rd_ok) begin
						out_key_q  <= rd_key;
						out_data_q <= rd_data;
					end else begin
						out_status_q <= ST_RANGE;
					end
				end
				CMD_INSERT: begin
					if (ins_range) begin
						out_status_q <= ST_RANGE;
					end else if (ins_full) begin
						out_status_q <= ST_FULL;
					end else begin
						out_cnt_q <= cnt_q + CW'(1);
					end
				end
				CMD_DELETE: begin
					if (del_range) begin
						out_status_q <= ST_RANGE;
					end else begin
						out_cnt_q <= CW'(cnt_c - n_c);
					end
				end
				default: begin
					out_cnt_q <= '0;
				end
			endcase
		end
	end

	logic [CMPW-1:0] out_cnt_c;
	assign out_cnt_c = CMPW'(out_cnt_q);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {
		7'd0,
		out_cnt_c[COUNT_BITS-1:0],
		WORD_BITS'(out_data_q),
		WORD_BITS'(out_key_q),
		out_status_q
	};

endmodule

`default_nettype wire

// ===== sv/itbl_cell.sv =====
// One slot of the table: a key/data pair that moves to or from its neighbors.
`default_nettype none

module itbl_cell import itbl_pkg::*; #(
	parameter int KEY_BITS  = KEY_BITS_DEF,
	parameter int DATA_BITS = DATA_BITS_DEF,
	parameter int IDX_BITS  = POS_BITS,
	parameter int CELL_IDX  = 0
) (
	input  wire  logic                 clk,
	input  wire  logic                 arst_n,
	input  wire  itbl_ctrl_t           ctrl,
	input  wire  logic [KEY_BITS-1:0]  key_new,
	input  wire  logic [DATA_BITS-1:0] data_new,
	input  wire  logic [KEY_BITS-1:0]  key_left,
	input  wire  logic [DATA_BITS-1:0] data_left,
	input  wire  logic [KEY_BITS-1:0]  key_right,
	input  wire  logic [DATA_BITS-1:0] data_right,
	output logic       [KEY_BITS-1:0]  key_q,
	output logic       [DATA_BITS-1:0] data_q,
	output logic       [KEY_BITS-1:0]  key_sel,
	output logic       [DATA_BITS-1:0] data_sel
);

	localparam int CMPW = (IDX_BITS > POS_BITS) ? IDX_BITS : POS_BITS;
	localparam logic [CMPW-1:0] MY_IDX = CMPW'(CELL_IDX);

	logic [CMPW-1:0] pos_c;
	logic            at_pos;
	logic            above_pos;

	assign pos_c     = CMPW'(ctrl.pos);
	assign at_pos    = (MY_IDX == pos_c);
	assign above_pos = (MY_IDX > pos_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			data_q <= '0;
		end else begin
			case (ctrl.op)
				OP_INSERT: begin
					if (at_pos) begin
						key_q  <= key_new;
						data_q <= data_new;
					end else if (above_pos) begin
						key_q  <= key_left;
						data_q <= data_left;
					end
				end
				OP_SHIFT_DOWN: begin
					if (at_pos || above_pos) begin
						key_q  <= key_right;
						data_q <= data_right;
					end
				end
				OP_CLEAR: begin
					key_q  <= '0;
					data_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Read port: only the addressed cell drives a nonzero value onto the OR bus.
	assign key_sel  = at_pos ? key_q : '0;
	assign data_sel = at_pos ? data_q : '0;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the indexed insert/delete table.
`timescale 1ns / 100ps

module testbench;
	import itbl_pkg::*;

	// A run of STALL_LIMIT quiet clocks with no transfer on either stream counts as a hang.
	// The slowest correct gap combines the receiver's LONG_HOLD hold,
	// a full-depth delete and the longest idle draws on both sides.
	localparam int STALL_LIMIT = 1000;
	localparam int LONG_HOLD   = 150;

	// One expected result transfer, split into its fields.
	typedef struct {
		logic [STATUS_BITS-1:0] status;
		logic [WORD_BITS-1:0]   key;
		logic [WORD_BITS-1:0]   data;
		logic [COUNT_BITS-1:0]  count;
	} table_reply_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CAP_BITS-1:0] cfg_wdata = '0;
	logic                s_tvalid  = 1'b0;
	logic [143:0]        s_tdata   = '0;
	logic [CMD_BITS-1:0] s_tuser   = CMD_READ;
	logic                m_tready  = 1'b0;
	wire                 s_tready;
	wire                 m_tvalid;
	wire  [143:0]        m_tdata;

	// Shadow copy of the table contents, the entry count and the capacity register.
	logic [WORD_BITS-1:0] key_tbl  [TABLE_DEPTH_DEF] = '{default: '0};
	logic [WORD_BITS-1:0] data_tbl [TABLE_DEPTH_DEF] = '{default: '0};
	int                   entries    = 0;
	logic [CAP_BITS-1:0]  cap_shadow = CAP_RESET;

	// Results still owed by the block, oldest first.
	table_reply_t replies_due [$];

	int mismatches   = 0;
	int quiet_cycles = 0;

	// Idle control: a steady side never pauses, and a pending hold makes the
	// receiver back off for a long stretch after its next transfer.
	bit tx_steady    = 1'b0;
	bit rx_steady    = 1'b0;
	bit hold_pending = 1'b0;

	indexed_insert_delete_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Runs one command against the shadow table and returns the result it must give.
	// Vacated slots are zeroed so that a later read of a shifted slot stays exact.
	function automatic table_reply_t model_command(input logic [CMD_BITS-1:0] cmd,
			input logic [POS_BITS-1:0] pos, input logic [NR_BITS-1:0] nr,
			input logic [WORD_BITS-1:0] key, input logic [WORD_BITS-1:0] dat);
		table_reply_t r;
		int p;
		int n;
		int i;
		int lim;
		r   = '{ST_OK, '0, '0, '0};
		p   = pos;
		lim = (cap_shadow < TABLE_DEPTH_DEF) ? cap_shadow : TABLE_DEPTH_DEF;
		case (cmd)
			CMD_READ: begin
				if (p < entries) begin
					r.key  = key_tbl[p];
					r.data = data_tbl[p];
				end else begin
					r.status = ST_RANGE;
				end
			end
			CMD_INSERT: begin
				// The position check wins over the full check.
				if (p > entries) begin
					r.status = ST_RANGE;
				end else if (entries >= lim) begin
					r.status = ST_FULL;
				end else begin
					for (i = entries; i > p; i--) begin
						key_tbl[i]  = key_tbl[i-1];
						data_tbl[i] = data_tbl[i-1];
					end
					key_tbl[p]  = key;
					data_tbl[p] = dat;
					entries++;
				end
			end
			CMD_DELETE: begin
				if (p >= entries) begin
					r.status = ST_RANGE;
				end else begin
					// The count is clipped to the entries from the position to the end.
					n = entries - p;
					if (int'(nr) < n) begin
						n = nr;
					end
					for (i = p; i + n < entries; i++) begin
						key_tbl[i]  = key_tbl[i+n];
						data_tbl[i] = data_tbl[i+n];
					end
					for (i = entries - n; i < entries; i++) begin
						key_tbl[i]  = '0;
						data_tbl[i] = '0;
					end
					entries -= n;
				end
			end
			default: begin
				for (i = 0; i < TABLE_DEPTH_DEF; i++) begin
					key_tbl[i]  = '0;
					data_tbl[i] = '0;
				end
				entries = 0;
			end
		endcase
		r.count = COUNT_BITS'(entries);
		return r;
	endfunction

	// Offers one command and returns at the edge of its transfer, with s_tvalid
	// still high. The caller either sends again at once or lowers it through
	// settle_block in the same time step.
	task automatic send_command(input logic [CMD_BITS-1:0] cmd,
			input logic [POS_BITS-1:0] pos, input logic [NR_BITS-1:0] nr,
			input logic [WORD_BITS-1:0] key, input logic [WORD_BITS-1:0] dat);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {3'b000, dat, key, nr, pos};
		do @(posedge clk); while (!s_tready);
		replies_due.push_back(model_command(cmd, pos, nr, key, dat));
	endtask

	// Stops offering commands and waits until every owed result has been taken.
	// Every command yields a result, so the block is idle once the queue drains.
	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_BITS-1:0] value);
		settle_block();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we     <= 1'b0;
		cap_shadow = value;
		@(posedge clk);
	endtask

	// Every command on a table that holds nothing must be refused or be a no-op.
	task automatic test_empty_table();
		send_command(CMD_READ,   6'd63, 7'd0, '0, '0);
		send_command(CMD_DELETE, 6'd0,  7'd5, '0, '0);
		send_command(CMD_INSERT, 6'd1,  7'd0, 64'h1234_5678_9ABC_DEF0, 64'h1);
	endtask

	// Inserts at the front, at the end and in the middle, then reads back
	// including one position just past the end.
	task automatic test_insert_and_read();
		send_command(CMD_INSERT, 6'd0, 7'd0, '1, '0);
		send_command(CMD_INSERT, 6'd0, 7'd0, '0, '1);
		send_command(CMD_INSERT, 6'd2, 7'd0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		send_command(CMD_INSERT, 6'd1, 7'd0, {$urandom, $urandom}, {$urandom, $urandom});
		send_command(CMD_READ,   6'd0, 7'd0, '0, '0);
		send_command(CMD_READ,   6'd3, 7'd0, '0, '0);
		send_command(CMD_READ,   6'd4, 7'd0, '0, '0);
	endtask

	// Four entries are live here. Covers a zero count, a start past the end,
	// a run in the middle and a count clipped at the end of the table.
	task automatic test_range_delete();
		send_command(CMD_DELETE, 6'd1, 7'd0,   '0, '0);
		send_command(CMD_DELETE, 6'd4, 7'd1,   '0, '0);
		send_command(CMD_DELETE, 6'd1, 7'd2,   '0, '0);
		send_command(CMD_READ,   6'd1, 7'd0,   '0, '0);
		send_command(CMD_DELETE, 6'd0, 7'd127, '1, '1);
		send_command(CMD_READ,   6'd0, 7'd0,   '0, '0);
	endtask

	// Walks the capacity register through zero, small values, a value below
	// the live count and the largest encodable value, and ends with a clear.
	task automatic test_capacity_limit();
		write_capacity(7'd0);
		send_command(CMD_INSERT, 6'd0, 7'd0, '1, '1);
		send_command(CMD_INSERT, 6'd1, 7'd0, '1, '1);
		write_capacity(7'd2);
		send_command(CMD_INSERT, 6'd0, 7'd0, 64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0);
		send_command(CMD_INSERT, 6'd1, 7'd0, 64'hFFFF_0000_FFFF_0000, 64'h0000_FFFF_0000_FFFF);
		send_command(CMD_INSERT, 6'd2, 7'd0, '1, '1);
		send_command(CMD_INSERT, 6'd3, 7'd0, '1, '1);
		// With the limit below the live count nothing is dropped, inserts just stop.
		write_capacity(7'd1);
		send_command(CMD_INSERT, 6'd0, 7'd0, '1, '1);
		send_command(CMD_DELETE, 6'd1, 7'd1, '0, '0);
		send_command(CMD_INSERT, 6'd0, 7'd0, '1, '1);
		write_capacity(7'd127);
		send_command(CMD_INSERT, 6'd1, 7'd0, {$urandom, $urandom}, {$urandom, $urandom});
		send_command(CMD_CLEAR,  6'd0, 7'd0, '0, '0);
	endtask

	// Sends a stream of commands whose mix is set by the percentages. Most
	// positions are legal for the current count so that shifts really happen.
	task automatic run_traffic_phase(input int items, input int clr_pct, input int ins_pct,
			input int del_pct, input int big_pct);
		int k;
		int roll;
		int p;
		logic [CMD_BITS-1:0]  cmd;
		logic [NR_BITS-1:0]   nr;
		logic [WORD_BITS-1:0] key;
		logic [WORD_BITS-1:0] dat;
		tx_steady = ($urandom_range(0, 3) == 0);
		rx_steady = ($urandom_range(0, 3) == 0);
		for (k = 0; k < items; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < clr_pct) begin
				cmd = CMD_CLEAR;
			end else if (roll < clr_pct + ins_pct) begin
				cmd = CMD_INSERT;
			end else if (roll < clr_pct + ins_pct + del_pct) begin
				cmd = CMD_DELETE;
			end else begin
				cmd = CMD_READ;
			end
			if ($urandom_range(0, 99) < 85) begin
				if (cmd == CMD_INSERT) begin
					p = $urandom_range(0, (entries < TABLE_DEPTH_DEF) ? entries : TABLE_DEPTH_DEF - 1);
				end else begin
					p = (entries > 0) ? $urandom_range(0, entries - 1) : 0;
				end
			end else begin
				p = $urandom_range(0, TABLE_DEPTH_DEF - 1);
			end
			nr = ($urandom_range(0, 99) < big_pct) ? NR_BITS'($urandom_range(0, 127))
				: NR_BITS'($urandom_range(0, 3));
			case ($urandom_range(0, 9))
				0: begin
					key = '1;
					dat = '0;
				end
				1: begin
					key = '0;
					dat = '1;
				end
				default: begin
					key = {$urandom, $urandom};
					dat = {$urandom, $urandom};
				end
			endcase
			send_command(cmd, POS_BITS'(p), nr, key, dat);
		end
	endtask

	// The receiver backs off for a long stretch while the sender keeps offering,
	// so the output register fills and the input must stall.
	task automatic test_backpressure();
		write_capacity(7'd64);
		hold_pending = 1'b1;
		tx_steady    = 1'b1;
		run_traffic_phase(20, 0, 60, 20, 10);
		tx_steady = 1'b1;
		settle_block();
	endtask

	// Random phases over several capacity settings: a fill to the full depth,
	// mixed traffic, a limit below the count and delete-heavy draining.
	task automatic test_random_traffic();
		write_capacity(7'd64);
		run_traffic_phase(55, 0, 90, 5, 0);
		run_traffic_phase(55, 2, 40, 30, 10);
		write_capacity(7'd127);
		run_traffic_phase(55, 2, 45, 30, 10);
		write_capacity(CAP_BITS'($urandom_range(1, 63)));
		run_traffic_phase(55, 2, 50, 25, 10);
		write_capacity(7'd0);
		run_traffic_phase(50, 2, 40, 30, 20);
		write_capacity(CAP_BITS'(entries / 2));
		run_traffic_phase(55, 0, 45, 30, 10);
		write_capacity(7'd64);
		run_traffic_phase(55, 0, 85, 10, 5);
		run_traffic_phase(55, 1, 20, 60, 30);
		run_traffic_phase(55, 2, 45, 30, 15);
	endtask

	// Result receiver: draws a pause before each transfer and honors a long
	// hold when one is pending.
	initial begin : result_sink
		int hold;
		while (!arst_n) @(posedge clk);
		forever begin
			hold = rx_steady ? 0 : $urandom_range(0, 11);
			if (hold_pending) begin
				hold         = hold + LONG_HOLD;
				hold_pending = 1'b0;
			end
			if (hold > 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Each result transfer is matched against the oldest expectation.
	always @(posedge clk) begin : result_check
		table_reply_t want;
		if (m_tvalid && m_tready) begin
			if (replies_due.size() == 0) begin
				$error("result transfer with no command outstanding, status %0d", m_tdata[1:0]);
				mismatches++;
			end else begin
				want = replies_due.pop_front();
				if (m_tdata[1:0] !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, m_tdata[1:0]);
					mismatches++;
				end
				if (m_tdata[65:2] !== want.key) begin
					$error("key_out: expected %h, actual %h", want.key, m_tdata[65:2]);
					mismatches++;
				end
				if (m_tdata[129:66] !== want.data) begin
					$error("data_out: expected %h, actual %h", want.data, m_tdata[129:66]);
					mismatches++;
				end
				if (m_tdata[136:130] !== want.count) begin
					$error("entry_count_now: expected %0d, actual %0d", want.count,
						m_tdata[136:130]);
					mismatches++;
				end
			end
		end
	end

	// Hang detection: any transfer on either stream restarts the count.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_insert_and_read();
		test_range_delete();
		test_capacity_limit();
		test_backpressure();
		test_random_traffic();
		settle_block();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && replies_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== indexed_insert_delete_table.f =====
sv/itbl_pkg.sv
sv/itbl_cell.sv
sv/indexed_insert_delete_table.sv
test/testbench.sv
